### rtl/core/mpfb_pkg.sv
// shared types, constants and codes of the page-packed monochrome pixel engine
// no dependencies
`default_nettype none

package mpfb_pkg;

  // display geometry and brightness scaling
  localparam int DISPLAY_WIDTH      = 128;
  localparam int DISPLAY_HEIGHT     = 64;
  localparam int PAGE_ROWS          = 8;
  localparam int BRIGHTNESS_DIVISOR = 256;
  localparam int MAX_LEVEL          = 255;

  localparam int STORE_BYTES = (DISPLAY_WIDTH * DISPLAY_HEIGHT) / PAGE_ROWS;
  localparam int IDX_W       = $clog2(STORE_BYTES);
  localparam int PAGE_SH     = $clog2(PAGE_ROWS);
  localparam int BIT_W       = PAGE_SH;
  localparam int LIN_W       = 16;

  // field widths
  localparam int FUNC_W  = 2;
  localparam int X_W     = 8;
  localparam int Y_W     = 7;
  localparam int COLOR_W = 8;
  localparam int REG_W   = 8;
  localparam int CIDX_W  = 2;

  // brightness compare width: weighted sum vs threshold times divisor
  localparam int SUM_W  = $clog2(3 * 255 * 255 + 1);
  localparam int THRD_W = REG_W + $clog2(BRIGHTNESS_DIVISOR + 1);
  localparam int CMP_W  = (SUM_W > THRD_W) ? SUM_W : THRD_W;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_SET  = 2'd0,
    FN_DRAW = 2'd1,
    FN_READ = 2'd2
  } func_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_RED   = 2'd0,
    CFG_GREEN = 2'd1,
    CFG_BLUE  = 2'd2,
    CFG_THR   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RMW,
    BK_READ
  } bk_state_t;

  typedef struct packed {
    logic [REG_W-1:0] red_weight;
    logic [REG_W-1:0] green_weight;
    logic [REG_W-1:0] blue_weight;
    logic [REG_W-1:0] lit_threshold;
  } cfg_t;

  typedef struct packed {
    func_t            op;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [BIT_W-1:0] bit_sel;
    logic             lit;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/mpfb_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module mpfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/mpfb_front.sv
// front end: accepts items, clips coordinates, evaluates set-colour brightness
// depends on mpfb_pkg
`default_nettype none

module mpfb_front (
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  input  wire logic [mpfb_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [mpfb_pkg::X_W-1:0]      in_x_coord,
  input  wire logic [mpfb_pkg::Y_W-1:0]      in_y_coord,
  input  wire logic [mpfb_pkg::COLOR_W-1:0]  in_red,
  input  wire logic [mpfb_pkg::COLOR_W-1:0]  in_green,
  input  wire logic [mpfb_pkg::COLOR_W-1:0]  in_blue,
  input  wire mpfb_pkg::cfg_t                cfg,
  input  wire logic                          clear_busy,
  input  wire logic                          q_full,
  output      logic                          q_push,
  output      mpfb_pkg::cmd_t                q_cmd
);

  logic                                x_ok;
  logic                                y_ok;
  logic [mpfb_pkg::LIN_W-1:0]          lin;
  logic                                lin_ok;
  logic                                in_rng;
  logic [2*mpfb_pkg::COLOR_W-1:0]      prod_r;
  logic [2*mpfb_pkg::COLOR_W-1:0]      prod_g;
  logic [2*mpfb_pkg::COLOR_W-1:0]      prod_b;
  logic [mpfb_pkg::CMP_W-1:0]          bsum;
  logic [mpfb_pkg::CMP_W-1:0]          thr_scaled;
  logic                                lit;
  logic                                accept;

  assign in_tready = !clear_busy && !q_full;
  assign accept    = in_tvalid && in_tready;

  // clipping and page addressing
  assign x_ok   = {1'b0, in_x_coord} < (mpfb_pkg::X_W + 1)'(mpfb_pkg::DISPLAY_WIDTH);
  assign y_ok   = {1'b0, in_y_coord} < (mpfb_pkg::Y_W + 1)'(mpfb_pkg::DISPLAY_HEIGHT);
  assign lin    = mpfb_pkg::LIN_W'(in_y_coord >> mpfb_pkg::PAGE_SH)
                  * mpfb_pkg::LIN_W'(mpfb_pkg::DISPLAY_WIDTH)
                  + mpfb_pkg::LIN_W'(in_x_coord);
  assign lin_ok = lin < mpfb_pkg::LIN_W'(mpfb_pkg::STORE_BYTES);
  assign in_rng = x_ok && y_ok && lin_ok;

  // floor(sum / div) >= thr  <=>  sum >= thr * div, saturation only matters via max level
  assign prod_r     = (2*mpfb_pkg::COLOR_W)'(in_red)   * (2*mpfb_pkg::COLOR_W)'(cfg.red_weight);
  assign prod_g     = (2*mpfb_pkg::COLOR_W)'(in_green) * (2*mpfb_pkg::COLOR_W)'(cfg.green_weight);
  assign prod_b     = (2*mpfb_pkg::COLOR_W)'(in_blue)  * (2*mpfb_pkg::COLOR_W)'(cfg.blue_weight);
  assign bsum       = mpfb_pkg::CMP_W'(prod_r) + mpfb_pkg::CMP_W'(prod_g)
                      + mpfb_pkg::CMP_W'(prod_b);
  assign thr_scaled = mpfb_pkg::CMP_W'(cfg.lit_threshold)
                      * mpfb_pkg::CMP_W'(mpfb_pkg::BRIGHTNESS_DIVISOR);
  assign lit        = (bsum >= thr_scaled)
                      && (mpfb_pkg::CMP_W'(mpfb_pkg::MAX_LEVEL)
                          >= mpfb_pkg::CMP_W'(cfg.lit_threshold));

  always_comb begin
    q_cmd.op       = mpfb_pkg::FN_SET;
    q_cmd.in_range = in_rng;
    q_cmd.idx      = lin[mpfb_pkg::IDX_W-1:0];
    q_cmd.bit_sel  = in_y_coord[mpfb_pkg::BIT_W-1:0];
    q_cmd.lit      = lit;
    q_push         = 1'b0;
    case (in_func)
      mpfb_pkg::FN_SET: begin
        q_cmd.op = mpfb_pkg::FN_SET;
        q_push   = accept;
      end
      mpfb_pkg::FN_DRAW: begin
        // clipped draws are dropped here
        q_cmd.op = mpfb_pkg::FN_DRAW;
        q_push   = accept && in_rng;
      end
      mpfb_pkg::FN_READ: begin
        q_cmd.op = mpfb_pkg::FN_READ;
        q_push   = accept;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/mpfb_queue.sv
// short command queue decoupling front and back
// depends on mpfb_pkg
`default_nettype none

module mpfb_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire mpfb_pkg::cmd_t push_cmd,
  output      logic           full,
  input  wire logic           pop,
  output      logic           head_valid,
  output      mpfb_pkg::cmd_t head_cmd
);

  mpfb_pkg::cmd_t               slot_r [mpfb_pkg::QDEPTH];
  logic [mpfb_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [mpfb_pkg::QPTR_W-1:0]  wr_ptr_nxt;
  logic [mpfb_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [mpfb_pkg::QPTR_W-1:0]  rd_ptr_nxt;
  logic [mpfb_pkg::QCNT_W-1:0]  cnt_r;
  logic [mpfb_pkg::QCNT_W-1:0]  cnt_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign full       = cnt_r == mpfb_pkg::QCNT_W'(mpfb_pkg::QDEPTH);
  assign head_valid = cnt_r != '0;
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == mpfb_pkg::QPTR_W'(mpfb_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == mpfb_pkg::QPTR_W'(mpfb_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mpfb_back.sv
// back end: framebuffer clear pass, read-modify-write, pixel reads, result register
// depends on mpfb_pkg and mpfb_ram
`default_nettype none

module mpfb_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire mpfb_pkg::cmd_t q_cmd,
  output      logic           q_pop,
  output      logic           clear_busy,
  output      logic           out_tvalid,
  input  wire logic           out_tready,
  output      logic           out_pixel_lit,
  output      logic           out_in_range
);

  mpfb_pkg::bk_state_t        state_r;
  mpfb_pkg::bk_state_t        state_nxt;
  logic [mpfb_pkg::IDX_W-1:0] clr_cnt_r;
  logic                       clr_last;
  logic                       active_lit_r;
  mpfb_pkg::cmd_t             cur_r;
  logic                       out_tvalid_r;
  logic                       out_lit_r;
  logic                       out_rng_r;
  logic                       out_lit_nxt;
  logic                       out_rng_nxt;
  logic                       out_load;
  logic                       out_free;
  logic                       ram_we;
  logic [mpfb_pkg::IDX_W-1:0] ram_waddr;
  logic [7:0]                 ram_wdata;
  logic                       ram_re;
  logic [7:0]                 ram_rdata;
  logic [7:0]                 mask;

  assign clr_last   = clr_cnt_r == mpfb_pkg::IDX_W'(mpfb_pkg::STORE_BYTES - 1);
  assign out_free   = !out_tvalid_r || out_tready;
  assign mask       = 8'(1) << cur_r.bit_sel;
  assign clear_busy = state_r == mpfb_pkg::BK_CLEAR;

  mpfb_ram #(
    .WIDTH (8),
    .DEPTH (mpfb_pkg::STORE_BYTES)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_cmd.idx),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpfb_pkg::BK_CLEAR: begin
        if (clr_last) begin
          state_nxt = mpfb_pkg::BK_IDLE;
        end
      end
      mpfb_pkg::BK_IDLE: begin
        if (q_valid && q_cmd.op == mpfb_pkg::FN_DRAW) begin
          state_nxt = mpfb_pkg::BK_RMW;
        end else if (q_valid && q_cmd.op == mpfb_pkg::FN_READ && q_cmd.in_range) begin
          state_nxt = mpfb_pkg::BK_READ;
        end
      end
      mpfb_pkg::BK_RMW: begin
        state_nxt = mpfb_pkg::BK_IDLE;
      end
      mpfb_pkg::BK_READ: begin
        if (out_free) begin
          state_nxt = mpfb_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = mpfb_pkg::BK_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    q_pop       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = cur_r.idx;
    ram_wdata   = '0;
    out_load    = 1'b0;
    out_lit_nxt = 1'b0;
    out_rng_nxt = 1'b0;
    case (state_r)
      mpfb_pkg::BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
      end
      mpfb_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            mpfb_pkg::FN_SET: begin
              q_pop = 1'b1;
            end
            mpfb_pkg::FN_DRAW: begin
              q_pop  = 1'b1;
              ram_re = 1'b1;
            end
            mpfb_pkg::FN_READ: begin
              if (q_cmd.in_range) begin
                q_pop  = 1'b1;
                ram_re = 1'b1;
              end else if (out_free) begin
                // clipped read answers unlit, out of range
                q_pop    = 1'b1;
                out_load = 1'b1;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      mpfb_pkg::BK_RMW: begin
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata & ~mask) | (active_lit_r ? mask : 8'h00);
      end
      mpfb_pkg::BK_READ: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_lit_nxt = ram_rdata[cur_r.bit_sel];
          out_rng_nxt = 1'b1;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mpfb_pkg::BK_CLEAR;
      clr_cnt_r    <= '0;
      active_lit_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == mpfb_pkg::BK_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (q_pop && q_cmd.op == mpfb_pkg::FN_SET) begin
        active_lit_r <= q_cmd.lit;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
    if (out_load) begin
      out_lit_r <= out_lit_nxt;
      out_rng_r <= out_rng_nxt;
    end
  end

  assign out_tvalid    = out_tvalid_r;
  assign out_pixel_lit = out_lit_r;
  assign out_in_range  = out_rng_r;

endmodule

`default_nettype wire

### rtl/core/mono_page_framebuffer_pixel_engine_unit.sv
// top level of the page-packed monochrome framebuffer pixel engine
// depends on mpfb_pkg, mpfb_front, mpfb_queue, mpfb_back (and mpfb_ram below it)
//
// usage:
//  - in_* stream carries one command per transaction: set colour, draw pixel or
//    read pixel (func in tuser); only reads produce an out_* transaction
//  - cfg_* is a plain write port for the rgb weights and the lit threshold; the user
//    writes it only while the engine is idle, which the block does not enforce
//  - the front clips coordinates and evaluates the brightness compare in the
//    accept cycle, then drops the command into a two-entry queue
//  - the back takes one queued command per visit to its idle state: set colour
//    is handled in idle, draw reads the ram and then writes it, read reads the ram
//    and then loads the result register; clipped reads load the result from idle
//  - reads pass the queue, the ram read and the result register; clipped reads skip the ram
//  - the back finishes each ram access before it pops the next command, so a new
//    draw or read is not taken until the one before it is through
//  - after reset the back sweeps all STORE_BYTES (1024) bytes of the framebuffer
//    to zero, one byte per cycle; in_tready stays low meanwhile, cfg writes
//    are taken as usual
//  - when the receiver stalls the result holds in the output register, the back
//    waits and the queue fills, then in_tready drops
`default_nettype none

module mono_page_framebuffer_pixel_engine_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input stream
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  input  wire logic [39:0]                   in_tdata,  // x_coord[7:0], y_coord[14:8],
                                                        // red[22:15], green[30:23],
                                                        // blue[38:31], zero pad
  input  wire logic [mpfb_pkg::FUNC_W-1:0]   in_tuser,  // func[1:0]
  // result stream
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  output      logic [7:0]                    out_tdata, // pixel_lit[0], in_range[1], zero pad
  // configuration writes
  input  wire logic                          cfg_we,
  input  wire logic [mpfb_pkg::CIDX_W-1:0]   cfg_index,
  input  wire logic [mpfb_pkg::REG_W-1:0]    cfg_wdata
);

  mpfb_pkg::cfg_t cfg_r;
  mpfb_pkg::cfg_t cfg_nxt;
  mpfb_pkg::cmd_t push_cmd;
  mpfb_pkg::cmd_t head_cmd;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           head_valid;
  logic           clear_busy;
  logic           pixel_lit;
  logic           in_range;

  // config register file, indexed by the register codes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        mpfb_pkg::CFG_RED:   cfg_nxt.red_weight    = cfg_wdata;
        mpfb_pkg::CFG_GREEN: cfg_nxt.green_weight  = cfg_wdata;
        mpfb_pkg::CFG_BLUE:  cfg_nxt.blue_weight   = cfg_wdata;
        mpfb_pkg::CFG_THR:   cfg_nxt.lit_threshold = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_weight    <= 8'd77;
      cfg_r.green_weight  <= 8'd150;
      cfg_r.blue_weight   <= 8'd29;
      cfg_r.lit_threshold <= 8'd128;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: accept, clip, classify
  mpfb_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .in_x_coord (in_tdata[7:0]),
    .in_y_coord (in_tdata[14:8]),
    .in_red     (in_tdata[22:15]),
    .in_green   (in_tdata[30:23]),
    .in_blue    (in_tdata[38:31]),
    .cfg        (cfg_r),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  // decoupling queue
  mpfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // back: framebuffer access and result register
  mpfb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (head_valid),
    .q_cmd         (head_cmd),
    .q_pop         (q_pop),
    .clear_busy    (clear_busy),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_pixel_lit (pixel_lit),
    .out_in_range  (in_range)
  );

  assign out_tdata = {6'b000000, in_range, pixel_lit};

  // no command taken while the clear sweep runs
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !in_tready)
    else $error("input accepted during framebuffer clear");

  // reset always starts the clear sweep
  a_reset_starts_clear: assert property (@(posedge clk)
    !rst_n |=> clear_busy)
    else $error("clear sweep not started after reset");

  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command queue overflow");

  // a lit pixel is always an in-range pixel
  a_lit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> out_tdata[1])
    else $error("lit result outside the display");

endmodule

`default_nettype wire
